[hdl/sha1_bsh_pkg.sv]
`timescale 1ns / 1ps

package sha1_bsh_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_H    = 5;
    localparam int ROUNDS   = 80;
    localparam int SCHED_D  = 16;

    localparam logic [WORD_W-1:0] H_INIT [NUM_H] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_00_19 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] FILL_LEN_POS = 6'd56;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [2:0] WORD_LAST    = 3'd4;

    // Working variables of the compression.
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } work_t;

    // Control from the sequencer to the message schedule.
    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] load_word;
        logic              step;
    } sched_ctl_t;

    function automatic logic [WORD_W-1:0] round_k(input logic [6:0] idx);
        logic [WORD_W-1:0] k;
        if (idx < 7'd20)
            k = K_00_19;
        else if (idx < 7'd40)
            k = K_20_39;
        else if (idx < 7'd60)
            k = K_40_59;
        else
            k = K_60_79;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

[hdl/sha1_byte_stream_hasher_top.sv]
`timescale 1ns / 1ps
// Channel  | Dir | tdata                              | tuser          | tlast
// s_axis   | in  | [7:0] data_byte                    | has_byte       | last
// m_axis   | out | [31:0] digest_word, [34:32] index  | length_error   | last_word
//
// A message byte is taken whenever the hasher is idle. The byte that completes
// a 64-byte block is followed by 80 rounds on the single round unit, then the
// chaining add. A last transaction pads byte by byte (with a turning step to
// the length bytes that writes nothing), runs one or two compressions and then
// offers five digest words, one per cycle when m_tready is held high. Reset loads
// the initial chaining words and clears the counts; the output side may stall for
// any length of time.

module sha1_byte_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tuser,   // [0] length_error
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic        ovf_reg, ovf_next;
    logic        fin_reg, fin_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_done_reg, len_done_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [31:0] chain_reg [sha1_bsh_pkg::NUM_H];
    logic [31:0] chain_next [sha1_bsh_pkg::NUM_H];

    sha1_bsh_pkg::work_t work_reg, work_next, work_round;
    logic [23:0] acc_reg, acc_next;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [64:0] len_sum;
    logic [63:0] len_shift;
    logic [31:0] w_cur;
    sha1_bsh_pkg::sched_ctl_t sched_ctl;

    sha1_bsh_sched u_sched
    (
        .clk   (clk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    sha1_bsh_round u_round
    (
        .round_idx (round_reg),
        .cur       (work_reg),
        .w         (w_cur),
        .nxt       (work_round)
    );

    assign len_sum   = {1'b0, bit_len_reg} + 65'd8;
    // Big-endian length byte for the position within the last eight bytes.
    assign len_shift = bit_len_reg >> {~fill_reg[2:0], 3'b000};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'b0, out_idx_reg, chain_reg[out_idx_reg]};
    assign m_tuser  = ovf_reg;
    assign m_tlast  = (out_idx_reg == sha1_bsh_pkg::WORD_LAST);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_len_next   = bit_len_reg;
        ovf_next       = ovf_reg;
        fin_next       = fin_reg;
        pad_first_next = pad_first_reg;
        len_done_next  = len_done_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        acc_next       = acc_reg;
        wr_en          = 1'b0;
        wr_byte        = 8'h00;
        sched_ctl.step = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        wr_en        = 1'b1;
                        wr_byte      = s_tdata;
                        bit_len_next = len_sum[63:0];
                        if (len_sum[64])
                            ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        fin_next       = 1'b1;
                        pad_first_next = 1'b1;
                        len_done_next  = 1'b0;
                    end
                    if (s_tuser && fill_reg == sha1_bsh_pkg::FILL_LAST)
                        state_next = ST_ROUND;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (!pad_first_reg && fill_reg == sha1_bsh_pkg::FILL_LEN_POS)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_byte        = pad_first_reg ? sha1_bsh_pkg::PAD_MARK : 8'h00;
                    pad_first_next = 1'b0;
                    if (fill_reg == sha1_bsh_pkg::FILL_LAST)
                        state_next = ST_ROUND;
                end
            end
            ST_LEN:
            begin
                wr_en   = 1'b1;
                wr_byte = len_shift[7:0];
                if (fill_reg == sha1_bsh_pkg::FILL_LAST)
                begin
                    len_done_next = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                sched_ctl.step = 1'b1;
                work_next      = work_round;
                round_next     = round_reg + 7'd1;
                if (round_reg == sha1_bsh_pkg::ROUND_LAST)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_done_reg)
                begin
                    out_idx_next = 3'd0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (out_idx_reg == sha1_bsh_pkg::WORD_LAST)
                    begin
                        chain_next    = sha1_bsh_pkg::H_INIT;
                        fill_next     = 6'd0;
                        bit_len_next  = 64'd0;
                        ovf_next      = 1'b0;
                        fin_next      = 1'b0;
                        len_done_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Shared byte path: three bytes gather, the fourth completes a word.
        if (wr_en)
        begin
            fill_next = fill_reg + 6'd1;
            acc_next  = {acc_reg[15:0], wr_byte};
        end
        sched_ctl.load      = wr_en && (fill_reg[1:0] == 2'b11);
        sched_ctl.load_word = {acc_reg, wr_byte};

        if (state_next == ST_ROUND && state_reg != ST_ROUND)
        begin
            round_next = 7'd0;
            work_next  = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                           d: chain_reg[3], e: chain_reg[4]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            bit_len_reg   <= 64'd0;
            ovf_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            len_done_reg  <= 1'b0;
            round_reg     <= 7'd0;
            out_idx_reg   <= 3'd0;
            chain_reg     <= sha1_bsh_pkg::H_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_len_reg   <= bit_len_next;
            ovf_reg       <= ovf_next;
            fin_reg       <= fin_next;
            pad_first_reg <= pad_first_next;
            len_done_reg  <= len_done_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        acc_reg  <= acc_next;
    end

    // A compression only starts on a whole block.
    a_block_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND && state_next == ST_ROUND) |=> (fill_reg == 6'd0))
        else $error("compression started on a partial block");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= sha1_bsh_pkg::ROUND_LAST))
        else $error("round counter out of range");

    a_sides_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while digest is pending");

    a_digest_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=>
            (fill_reg == 6'd0 && bit_len_reg == 64'd0 && !ovf_reg && s_tready))
        else $error("state not cleared after digest");

    a_digest_after_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_OUT && state_next == ST_OUT) |-> (fin_reg && len_done_reg))
        else $error("digest offered before length block");

endmodule

[hdl/sha1_bsh_sched.sv]
`timescale 1ns / 1ps

module sha1_bsh_sched
(
    input  logic                           clk,
    input  sha1_bsh_pkg::sched_ctl_t       ctl,
    output logic [sha1_bsh_pkg::WORD_W-1:0] w_cur
);

    logic [sha1_bsh_pkg::WORD_W-1:0] w_reg [sha1_bsh_pkg::SCHED_D];
    logic [sha1_bsh_pkg::WORD_W-1:0] w_new;

    // The line holds W[t] .. W[t+15]; W[t+16] comes from fixed taps.
    assign w_new = sha1_bsh_pkg::rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign w_cur = w_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.load || ctl.step)
        begin
            for (int i = 0; i < sha1_bsh_pkg::SCHED_D - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha1_bsh_pkg::SCHED_D-1] <= ctl.load ? ctl.load_word : w_new;
        end
    end

endmodule

[hdl/sha1_bsh_round.sv]
`timescale 1ns / 1ps

module sha1_bsh_round
(
    input  logic [6:0]                      round_idx,
    input  sha1_bsh_pkg::work_t             cur,
    input  logic [sha1_bsh_pkg::WORD_W-1:0] w,
    output sha1_bsh_pkg::work_t             nxt
);

    logic [sha1_bsh_pkg::WORD_W-1:0] f;

    always_comb
    begin
        if (round_idx < 7'd20)
            f = (cur.b & cur.c) | (~cur.b & cur.d);
        else if (round_idx >= 7'd40 && round_idx < 7'd60)
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
        else
            f = cur.b ^ cur.c ^ cur.d;
    end

    always_comb
    begin
        nxt.a = sha1_bsh_pkg::rotl(cur.a, 5) + f + cur.e + w
              + sha1_bsh_pkg::round_k(round_idx);
        nxt.b = cur.a;
        nxt.c = sha1_bsh_pkg::rotl(cur.b, 30);
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // One digest word as it leaves the hasher.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_word;
        logic        len_err;
    } digest_beat_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         fin;
        logic         typed;
        logic [159:0] digest;
    } stim_row_t;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
    localparam logic [159:0] NO_DIGEST    = 160'h0;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Hash state as the testbench sees it.
    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] nbits;
    logic        ovf;

    digest_beat_t digest_q [$];
    int           mismatch_count = 0;
    int           counted_items = 0;
    bit           quiet = 1'b0;

    sha1_byte_stream_hasher_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic void clear_hash_state();
        int i;
        for (i = 0; i < 5; i++)
            chain[i] = sha1_bsh_pkg::H_INIT[i];
        for (i = 0; i < 64; i++)
            blk[i] = 8'h00;
        fill = 0;
        nbits = 64'd0;
        ovf = 1'b0;
    endfunction

    function automatic void hash_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (r = 16; r < 80; r++)
        begin
            t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {t[30:0], t[31]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_bsh_pkg::K_00_19;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_bsh_pkg::K_20_39;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_bsh_pkg::K_40_59;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_bsh_pkg::K_60_79;
            end
            t = {a[26:0], a[31:27]} + f + e + w[r] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
        fill = 0;
    endfunction

    // Absorbs one accepted transaction and queues the digest words that a last item yields.
    function automatic void hash_model_step(input logic [7:0] d, input logic has,
                                            input logic fin, input logic typed,
                                            input logic [159:0] typed_digest);
        digest_beat_t beat;
        int i;
        if (has)
        begin
            blk[fill] = d;
            fill++;
            nbits += 64'd8;
            if (nbits == 64'd0)
                ovf = 1'b1;
            if (fill == 64)
                hash_block();
        end
        if (fin)
        begin
            blk[fill] = sha1_bsh_pkg::PAD_MARK;
            fill++;
            // More than 55 bytes pending leaves no room for the length: spill into a second block.
            if (fill > 56)
            begin
                while (fill < 64)
                begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                hash_block();
            end
            while (fill < 56)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            for (i = 0; i < 8; i++)
                blk[56+i] = nbits[63-8*i -: 8];
            hash_block();
            for (i = 0; i < 5; i++)
            begin
                beat.word = typed ? typed_digest[159-32*i -: 32] : chain[i];
                beat.index = 3'(i);
                beat.final_word = (i == 4);
                beat.len_err = ovf;
                digest_q.push_back(beat);
            end
            clear_hash_state();
        end
    endfunction

    task automatic apply_item(input logic [7:0] d, input logic has, input logic fin,
                              input logic typed, input logic [159:0] typed_digest);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= has;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hash_model_step(d, has, fin, typed, typed_digest);
        counted_items++;
    endtask

    // Output side: a fresh stall before every word, none while quiet.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        digest_beat_t want;
        digest_beat_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[34:32], m_tlast, m_tuser};
            if (digest_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: digest word %h index %0d arrived with nothing expected",
                             $realtime, got.word, got.index);
            end
            else
            begin
                want = digest_q.pop_front();
                if (got != want || m_tdata[39:35] != 5'd0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: expected word %h index %0d last %b err %b",
                                 $realtime, want.word, want.index, want.final_word,
                                 want.len_err);
                        $display("%0t: got      word %h index %0d last %b err %b pad %h",
                                 $realtime, got.word, got.index, got.final_word,
                                 got.len_err, m_tdata[39:35]);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t directed_rows [$];
        int len;
        int n;
        bit empty_tail;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        rst_n = 1'b0;
        clear_hash_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_rows = '{
            '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle, nothing happens
            '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
            '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle inside a message
            '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
            '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h5a, 1'b0, 1'b1, 1'b0, NO_DIGEST},     // finishing item without a byte
            '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
            '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
            '{8'ha5, 1'b0, 1'b0, 1'b0, NO_DIGEST}
        };
        foreach (directed_rows[i])
            apply_item(directed_rows[i].data, directed_rows[i].has, directed_rows[i].fin,
                       directed_rows[i].typed, directed_rows[i].digest);

        // Lengths cluster round the padding boundaries at 55/56 and 63/64 bytes per block.
        while (counted_items < 150)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 8);
                4:          len = $urandom_range(54, 57);
                5:          len = $urandom_range(62, 66);
                6:          len = $urandom_range(118, 129);
                default:    len = $urandom_range(9, 40);
            endcase
            if (len > 150 - counted_items)
                len = 150 - counted_items;
            quiet = ($urandom_range(0, 4) == 0);
            empty_tail = ($urandom_range(0, 3) == 0);
            for (n = 0; n < len; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    apply_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
                apply_item(8'($urandom_range(0, 255)), 1'b1, (n == len - 1) && !empty_tail,
                           1'b0, NO_DIGEST);
            end
            if (len == 0 || empty_tail)
                apply_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
        end
        quiet = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (digest_q.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
